// ===== rtl/itf_pkg.sv =====
`timescale 1ns / 1ps

package itf_pkg;

    localparam int CW = 8;

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEXU = 3'd2;
    localparam logic [2:0] OP_HEXL = 3'd3;
    localparam logic [2:0] OP_PTR  = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] value;
        logic [6:0]  field_width;
        logic [5:0]  precision;
        logic        has_precision;
        logic        left_justify;
        logic        zero_pad;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out;

    typedef struct packed {
        logic start;
        logic hex;
        logic shift;
    } t_dig_ctl;

    typedef struct packed {
        logic       done;
        logic [3:0] top;
    } t_dig_sts;

endpackage

// ===== rtl/itf_digits.sv =====
`timescale 1ns / 1ps

module itf_digits #(
    parameter int DIGIT_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  itf_pkg::t_dig_ctl                i_ctl,
    input  logic [63:0]                      i_mag,
    output itf_pkg::t_dig_sts                o_sts,
    output logic [$clog2(DIGIT_SLOTS+1)-1:0] o_ndig
);
    import itf_pkg::*;

    localparam int DW = 4 * DIGIT_SLOTS;
    localparam int NW = $clog2(DIGIT_SLOTS + 1);
    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CONV = 2'd1;
    localparam logic [1:0] D_NORM = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [DW-1:0] r_dig, n_dig;
    logic [31:0]   r_bin, n_bin;
    logic [4:0]    r_bit, n_bit;
    logic [NW-1:0] r_ndig, n_ndig;
    logic [DW-1:0] w_adj;
    logic          w_more;

    // Double dabble: every BCD digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            w_adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? r_dig[4*i +: 4] + 4'd3
                                                          : r_dig[4*i +: 4];
        end
    end

    assign w_more = (r_dig[DW-1 -: 4] == 4'd0) && (r_ndig > NW'(1));

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_bin   = r_bin;
        n_bit   = r_bit;
        n_ndig  = r_ndig;
        case (r_state)
            D_IDLE: begin
                if (i_ctl.start) begin
                    n_ndig = NW'(DIGIT_SLOTS);
                    if (i_ctl.hex) begin
                        n_dig   = DW'(i_mag);
                        n_state = D_NORM;
                    end else begin
                        n_dig   = '0;
                        n_bin   = i_mag[31:0];
                        n_bit   = 5'd0;
                        n_state = D_CONV;
                    end
                end else if (i_ctl.shift) begin
                    n_dig = {r_dig[DW-5:0], 4'd0};
                end
            end
            D_CONV: begin
                n_dig = {w_adj[DW-2:0], r_bin[31]};
                n_bin = {r_bin[30:0], 1'b0};
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'd31) begin
                    n_state = D_NORM;
                end
            end
            D_NORM: begin
                if (w_more) begin
                    n_dig  = {r_dig[DW-5:0], 4'd0};
                    n_ndig = r_ndig - NW'(1);
                end else begin
                    n_state = D_IDLE;
                end
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dig  <= n_dig;
        r_bin  <= n_bin;
        r_bit  <= n_bit;
        r_ndig <= n_ndig;
    end

    assign o_sts.done = (r_state == D_NORM) && !w_more;
    assign o_sts.top  = r_dig[DW-1 -: 4];
    assign o_ndig     = r_ndig;

endmodule

// ===== rtl/integer_text_formatter.sv =====
`timescale 1ns / 1ps
// Steps: a decimal item passes bit-serial conversion, then leading-zero removal, the step that finds
// the first digit and the length setup before its first character is loaded; a hex item skips the
// conversion, and an item with an unused op code is taken but produces no text.
// Output: N characters (at most MAX_FIELD) leave one per cycle while the receiver does not stall;
// the next item is taken once the last character of the previous one has been loaded.
// Reset (synchronous, active low) returns to idle and drops any pending output transfer.
module integer_text_formatter #(
    parameter int MAX_FIELD   = 64,
    parameter int DIGIT_SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  itf_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output itf_pkg::t_out o_out_data
);
    import itf_pkg::*;

    localparam int NW = $clog2(DIGIT_SLOTS + 1);
    localparam logic [CW-1:0] MAXF = CW'(MAX_FIELD);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    logic [2:0]    r_state, n_state;
    logic          r_neg, r_upper, r_left, r_hasp, r_zpad;
    logic [1:0]    r_plen;
    logic [CW-1:0] r_fw;
    logic [5:0]    r_prec;
    logic [CW-1:0] r_sp, r_pl, r_zr, r_nd, r_emit, r_total;
    logic          r_ov;
    t_out          r_out;

    t_dig_ctl      w_ctl;
    t_dig_sts      w_sts;
    logic [NW-1:0] w_ndig;
    logic [63:0]   w_mag;
    logic [31:0]   w_v32;
    logic          w_accept, w_fire, w_last;
    logic [7:0]    w_char, w_dchar;
    logic [CW-1:0] w_nd, w_plen, w_zeros, w_body, w_spaces, w_full, w_fw_in;

    itf_digits #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_mag   (w_mag),
        .o_sts   (w_sts),
        .o_ndig  (w_ndig)
    );

    // The block takes a new item only when the previous one has finished emitting;
    // the output register may still hold the final character of that item.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Magnitude for the digit unit: signed decimal negates a negative 32-bit value.
    assign w_v32 = i_in_data.value[31:0];
    always_comb begin
        case (i_in_data.op)
            OP_SDEC: w_mag = {32'd0, w_v32[31] ? (~w_v32 + 32'd1) : w_v32};
            OP_PTR:  w_mag = i_in_data.value;
            default: w_mag = {32'd0, w_v32};
        endcase
    end

    assign w_fw_in = (CW'(i_in_data.field_width) > MAXF) ? MAXF
                                                         : CW'(i_in_data.field_width);

    // Length setup: zero fill, then the space padding, then the emitted total,
    // which is capped at the field limit.
    assign w_nd   = CW'(w_ndig);
    assign w_plen = CW'(r_plen);
    always_comb begin
        w_zeros = '0;
        if (r_hasp) begin
            if (CW'(r_prec) > w_nd) begin
                w_zeros = CW'(r_prec) - w_nd;
            end
        end else if (r_zpad && !r_left) begin
            if (r_fw > w_plen + w_nd) begin
                w_zeros = r_fw - w_plen - w_nd;
            end
        end
    end
    assign w_body   = w_plen + w_zeros + w_nd;
    assign w_spaces = (r_fw > w_body) ? r_fw - w_body : '0;
    assign w_full   = w_body + w_spaces;

    // In the emit state, one character may be loaded whenever the output register is empty or is
    // being drained by a transfer in this same cycle.
    assign w_fire = (r_state == S_EMIT) && (!r_ov || !i_out_stall);
    assign w_last = (r_emit + CW'(1) == r_total);

    always_comb begin
        if (w_sts.top < 4'd10) begin
            w_dchar = CH_ZERO + 8'(w_sts.top);
        end else begin
            w_dchar = (r_upper ? CH_UA : CH_LA) + 8'(w_sts.top) - 8'd10;
        end
    end

    // Segment order: leading spaces, sign or prefix, zero fill, digits, trailing spaces.
    always_comb begin
        if (!r_left && r_sp != '0) begin
            w_char = CH_SPACE;
        end else if (r_pl != '0) begin
            if (r_neg) begin
                w_char = CH_MINUS;
            end else begin
                w_char = (r_pl == CW'(2)) ? CH_ZERO : CH_X;
            end
        end else if (r_zr != '0) begin
            w_char = CH_ZERO;
        end else if (r_nd != '0) begin
            w_char = w_dchar;
        end else begin
            w_char = CH_SPACE;
        end
    end

    always_comb begin
        w_ctl.start = w_accept && (i_in_data.op <= OP_PTR);
        w_ctl.hex   = (i_in_data.op != OP_SDEC) && (i_in_data.op != OP_UDEC);
        w_ctl.shift = w_fire && !(!r_left && r_sp != '0) && (r_pl == '0)
                      && (r_zr == '0) && (r_nd != '0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_ctl.start) n_state = S_CONV;
            S_CONV: if (w_sts.done) n_state = S_CALC;
            S_CALC: n_state = S_EMIT;
            S_EMIT: if (w_fire && w_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end

        if (w_ctl.start) begin
            r_neg   <= (i_in_data.op == OP_SDEC) && w_v32[31];
            r_upper <= (i_in_data.op == OP_HEXU);
            r_left  <= i_in_data.left_justify;
            r_hasp  <= i_in_data.has_precision;
            r_zpad  <= i_in_data.zero_pad;
            r_prec  <= i_in_data.precision;
            r_fw    <= w_fw_in;
            if (w_ctl.hex) begin
                r_plen <= 2'd2;
            end else begin
                r_plen <= (w_v32[31] && i_in_data.op == OP_SDEC) ? 2'd1 : 2'd0;
            end
        end

        if (r_state == S_CALC) begin
            r_sp    <= w_spaces;
            r_pl    <= w_plen;
            r_zr    <= w_zeros;
            r_nd    <= w_nd;
            r_emit  <= '0;
            r_total <= (w_full > MAXF) ? MAXF : w_full;
        end else if (w_fire) begin
            r_emit <= r_emit + CW'(1);
            if (!r_left && r_sp != '0) begin
                r_sp <= r_sp - CW'(1);
            end else if (r_pl != '0) begin
                r_pl <= r_pl - CW'(1);
            end else if (r_zr != '0) begin
                r_zr <= r_zr - CW'(1);
            end else if (r_nd != '0) begin
                r_nd <= r_nd - CW'(1);
            end else begin
                r_sp <= r_sp - CW'(1);
            end
        end

        if (w_fire) begin
            r_out.out_char  <= w_char;
            r_out.last_char <= w_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

// ===== sim/itf_checker.sv =====
`timescale 1ns / 1ps

module itf_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  itf_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  itf_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    import itf_pkg::*;

    localparam int MAX_FIELD   = 64;
    localparam int DIGIT_SLOTS = 16;

    t_out text_q[$];

    assign o_pending = text_q.size();

    function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
        if (d < 10) return CH_ZERO + 8'(d);
        return (upper ? CH_UA : CH_LA) + 8'(d - 10);
    endfunction

    // Builds the expected character stream for one formatting request.
    task automatic format_text(input t_in req);
        logic [63:0] mag;
        logic [7:0]  pre[2];
        logic [7:0]  digs[DIGIT_SLOTS];
        logic [7:0]  chars[$];
        int          plen, ndig, zeros, spaces, fw, base, k;
        logic        upper;
        t_out        item;
        plen = 0; ndig = 0; zeros = 0; spaces = 0; base = 10;
        upper = (req.op == OP_HEXU);
        if (req.op > OP_PTR) return;
        fw = (req.field_width > MAX_FIELD) ? MAX_FIELD : int'(req.field_width);
        case (req.op)
            OP_SDEC: begin
                mag = {32'd0, req.value[31:0]};
                if (req.value[31]) begin
                    mag = {32'd0, (~req.value[31:0]) + 32'd1};
                    pre[0] = CH_MINUS;
                    plen = 1;
                end
            end
            OP_UDEC: mag = {32'd0, req.value[31:0]};
            default: begin
                base = 16;
                mag = (req.op == OP_PTR) ? req.value : {32'd0, req.value[31:0]};
                pre[0] = CH_ZERO;
                pre[1] = CH_X;
                plen = 2;
            end
        endcase
        do begin
            digs[ndig] = digit_char(4'(mag % base), upper);
            mag = mag / base;
            ndig++;
        end while (mag != 0 && ndig < DIGIT_SLOTS);
        if (req.has_precision) begin
            if (req.precision > ndig) zeros = req.precision - ndig;
        end else if (req.zero_pad && !req.left_justify) begin
            if (fw > plen + ndig) zeros = fw - plen - ndig;
        end
        if (fw > plen + zeros + ndig) spaces = fw - plen - zeros - ndig;
        if (!req.left_justify) repeat (spaces) chars.push_back(CH_SPACE);
        for (k = 0; k < plen; k++) chars.push_back(pre[k]);
        repeat (zeros) chars.push_back(CH_ZERO);
        for (k = ndig; k > 0; k--) chars.push_back(digs[k - 1]);
        if (req.left_justify) repeat (spaces) chars.push_back(CH_SPACE);
        while (chars.size() > MAX_FIELD) void'(chars.pop_back());
        for (k = 0; k < chars.size(); k++) begin
            item.out_char  = chars[k];
            item.last_char = (k == chars.size() - 1);
            text_q.push_back(item);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) format_text(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (text_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %02h", i_out_data.out_char));
                end else begin
                    want = text_q.pop_front();
                    if (i_out_data.out_char !== want.out_char)
                        report_mismatch($sformatf("char %02h, expected %02h",
                            i_out_data.out_char, want.out_char));
                    if (i_out_data.last_char !== want.last_char)
                        report_mismatch($sformatf("last %b, expected %b",
                            i_out_data.last_char, want.last_char));
                end
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import itf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    t_in   in_data = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    t_out  out_data;
    int    fail_count;
    int    pending;
    int    idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    integer_text_formatter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // The checker watches both channels, predicts the text and counts mismatches.
    itf_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The receiver stalls on its own pattern: calm stretches, light stalling and heavy stalling take turns.
    always @(negedge i_clk) begin
        int mode;
        mode = (int'($realtime) / 8000) % 3;
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(3) == 0);
        else out_stall <= ($urandom_range(1) == 0);
    end

    // The watchdog ends the run when nothing has been transferred for too long.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("integer_text_formatter verification failed");
            $finish;
        end
    end

    // Presents one request and holds it until the block accepts the transfer.
    task automatic send_request(input t_in req);
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    function automatic t_in make_request(logic [2:0] op, logic [63:0] value,
                                         logic [6:0] fw, logic [5:0] prec,
                                         logic hp, logic lj, logic zp);
        t_in r;
        r.op = op; r.value = value; r.field_width = fw; r.precision = prec;
        r.has_precision = hp; r.left_justify = lj; r.zero_pad = zp;
        return r;
    endfunction

    // Random requests favor short texts and valid ops, with occasional extremes.
    function automatic t_in random_request();
        t_in r;
        int  pick;
        r.op = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        pick = $urandom_range(5);
        case (pick)
            0: r.value = '0;
            1: r.value = '1;
            2: r.value = {$urandom, 32'h8000_0000};
            3: r.value = 64'($urandom_range(99));
            default: r.value = {$urandom, $urandom};
        endcase
        r.field_width = ($urandom_range(7) == 0) ? 7'($urandom_range(127, 60))
                                                 : 7'($urandom_range(20));
        r.precision = ($urandom_range(7) == 0) ? 6'($urandom_range(63, 40))
                                               : 6'($urandom_range(12));
        r.has_precision = 1'($urandom_range(1));
        r.left_justify  = 1'($urandom_range(1));
        r.zero_pad      = 1'($urandom_range(1));
        return r;
    endfunction

    initial begin
        int burst;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests: zeros, extremes, the most negative value, flag conflicts,
        // unused op codes and texts that are cut at the field limit.
        send_request(make_request(OP_SDEC, 64'd0, 7'd0, 6'd0, 1'b1, 1'b0, 1'b0));
        send_request(make_request(OP_UDEC, 64'd0, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(make_request(OP_HEXU, 64'd0, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(make_request(OP_HEXL, 64'd0, 7'd5, 6'd0, 1'b0, 1'b0, 1'b1));
        send_request(make_request(OP_PTR,  64'd0, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(make_request(OP_SDEC, 64'h8000_0000, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(make_request(OP_SDEC, 64'h7fff_ffff, 7'd14, 6'd0, 1'b0, 1'b0, 1'b1));
        send_request(make_request(OP_SDEC, '1, 7'd8, 6'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_request(OP_UDEC, '1, 7'd12, 6'd4, 1'b1, 1'b0, 1'b1));
        send_request(make_request(OP_HEXU, 64'hdead_beef, 7'd12, 6'd0, 1'b0, 1'b0, 1'b1));
        send_request(make_request(OP_HEXL, 64'hdead_beef, 7'd12, 6'd0, 1'b0, 1'b1, 1'b0));
        send_request(make_request(OP_PTR,  '1, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(make_request(OP_PTR,  64'h0123_4567_89ab_cdef, 7'd20, 6'd18,
                                  1'b1, 1'b1, 1'b1));
        send_request(make_request(3'd5, 64'd1, 7'd10, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(make_request(3'd7, '1, 7'd127, 6'd63, 1'b1, 1'b1, 1'b1));
        send_request(make_request(OP_SDEC, 64'hffff_ff85, 7'd64, 6'd63, 1'b1, 1'b0, 1'b0));
        send_request(make_request(OP_HEXL, 64'd255, 7'd127, 6'd0, 1'b0, 1'b0, 1'b1));
        send_request(make_request(OP_UDEC, 64'd42, 7'd100, 6'd0, 1'b0, 1'b1, 1'b0));
        send_request(make_request(OP_HEXU, 64'd1, 7'd0, 6'd63, 1'b1, 1'b0, 1'b0));
        send_request(make_request(OP_UDEC, 64'd7, 7'd65, 6'd0, 1'b0, 1'b0, 1'b1));

        // Random requests in bursts of random length with random gaps between them.
        for (int n = 0; n < 300; ) begin
            burst = $urandom_range(8, 1);
            for (int b = 0; b < burst; b++) begin
                send_request(random_request());
                n++;
            end
            if ($urandom_range(2) != 0) idle_gap($urandom_range(40));
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("integer_text_formatter verification clean");
        end else begin
            $display("integer_text_formatter verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/itf_pkg.sv
rtl/itf_digits.sv
rtl/integer_text_formatter.sv
sim/itf_checker.sv
sim/testbench.sv
